// ----- src/egbp_pkg.sv -----
`timescale 1ns / 1ps

package egbp_pkg;

    // Command codes carried on the input channel
    typedef logic [2:0] cmd_t;

    localparam cmd_t CMD_RAW   = 3'd0;
    localparam cmd_t CMD_UE    = 3'd1;
    localparam cmd_t CMD_SE    = 3'd2;
    localparam cmd_t CMD_ALIGN = 3'd3;
    localparam cmd_t CMD_CLEAR = 3'd4;

    // Bits per output byte and the offset that turns a code number into a code word
    localparam int BYTE_BITS = 8;
    localparam int CODE_ONE  = 1;

    // Pending partial-byte storage
    localparam int PART_W  = BYTE_BITS - 1;
    localparam int PCNT_W  = 3;

    typedef logic [PART_W-1:0] part_bits_t;
    typedef logic [PCNT_W-1:0] part_cnt_t;

endpackage

// ----- src/egbp_code.sv -----
`timescale 1ns / 1ps

module egbp_code
    import egbp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  cmd_t                                      command,
    input  logic [VALUE_WIDTH-1:0]                    value,
    input  logic [5:0]                                bit_count,
    input  part_cnt_t                                 partial_count,
    output logic [VALUE_WIDTH:0]                      code_bits,
    output logic [$clog2(2*VALUE_WIDTH+2)-1:0]        code_len,
    output logic                                      clear_partial
);

    localparam int CODE_W = VALUE_WIDTH + 1;
    localparam int MSB_W  = $clog2(CODE_W);
    localparam int LEN_W  = $clog2(2*VALUE_WIDTH+2);

    logic [5:0]             raw_n;
    logic [VALUE_WIDTH-1:0] raw_mask;
    logic [VALUE_WIDTH-1:0] neg_mag;
    logic [CODE_W-1:0]      se_num;
    logic [CODE_W-1:0]      code_num;
    logic [CODE_W-1:0]      ue_word;
    logic [MSB_W-1:0]       msb_idx;
    logic [LEN_W-1:0]       ue_len;

    // Saturate the raw length and keep only the low bits that are written
    assign raw_n    = (bit_count > 6'(VALUE_WIDTH)) ? 6'(VALUE_WIDTH) : bit_count;
    assign raw_mask = ~({VALUE_WIDTH{1'b1}} << raw_n);

    // Map the signed value onto a code number: positive to 2v-1, else to -2v
    assign neg_mag = ~value + VALUE_WIDTH'(1);

    always_comb
    begin
        if (value == '0)
        begin
            se_num = '0;
        end
        else if (!value[VALUE_WIDTH-1])
        begin
            se_num = {value, 1'b0} - CODE_W'(1);
        end
        else
        begin
            se_num = {neg_mag, 1'b0};
        end
    end

    assign code_num = (command == CMD_SE) ? se_num : {1'b0, value};
    assign ue_word  = code_num + CODE_W'(CODE_ONE);

    // Find the leading one of the code word; the prefix has that many zeros
    always_comb
    begin
        msb_idx = '0;
        for (int i = 0; i < CODE_W; i++)
        begin
            if (ue_word[i])
            begin
                msb_idx = MSB_W'(i);
            end
        end
    end

    assign ue_len = LEN_W'({msb_idx, 1'b1});

    // Select the bits to append and their count
    always_comb
    begin
        code_bits     = '0;
        code_len      = '0;
        clear_partial = 1'b0;
        unique case (command)
            CMD_RAW:
            begin
                code_bits = CODE_W'(value & raw_mask);
                code_len  = LEN_W'(raw_n);
            end
            CMD_UE, CMD_SE:
            begin
                code_bits = ue_word;
                code_len  = ue_len;
            end
            CMD_ALIGN:
            begin
                if (partial_count != '0)
                begin
                    code_len = LEN_W'(4'(BYTE_BITS) - {1'b0, partial_count});
                end
            end
            CMD_CLEAR:
            begin
                clear_partial = 1'b1;
            end
            default:
            begin
                code_len = '0;
            end
        endcase
    end

endmodule

// ----- src/exp_golomb_bit_packer.sv -----
`timescale 1ns / 1ps

// MSB-first bit packer for video bitstreams.
// Input channel (in_valid/in_ready): one command per beat with value and
// bit_count. Raw fields, ue(v) and se(v) codes are appended to the stream;
// align pads the pending partial byte with zeros; clear drops it.
// Output channel (out_valid/out_ready): one completed byte per beat, first
// written bit in bit 7; last_byte marks the final byte caused by a command.
// Path: a command is held in the input register, then coded and merged
// with the pending bits into the byte buffer register that offers its bytes.
// Throughput: the byte buffer drains one byte per cycle while out_ready is
// high; a command completes up to 4 bytes for a 32-bit raw field and up to
// 9 for the longest code; commands that complete no byte go one per
// cycle. A new command is taken while the last byte of the previous one
// is being delivered.
// Reset empties both registers and clears the pending bits.
// When the receiver stalls, the buffer holds its byte, the input register
// fills, and in_ready drops until the buffer can take the next command.
module exp_golomb_bit_packer
    import egbp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [31:0] value,
    input  logic [5:0]  bit_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    localparam int CODE_W  = VALUE_WIDTH + 1;
    localparam int LEN_W   = $clog2(2*VALUE_WIDTH+2);
    localparam int LEN_MAX = 2*VALUE_WIDTH + 1;
    localparam int BUF_W   = ((LEN_MAX + PART_W + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
    localparam int NBYTES  = BUF_W / BYTE_BITS;
    localparam int CNT_W   = $clog2(NBYTES + 1);
    localparam int TOT_W   = $clog2(BUF_W + 1);

    // Input register
    logic                   hold_valid_reg;
    cmd_t                   cmd_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [5:0]             count_reg;

    // Pending partial byte
    part_bits_t             partial_bits_reg;
    part_bits_t             partial_bits_next;
    part_cnt_t              partial_count_reg;
    part_cnt_t              partial_count_next;

    // Byte buffer feeding the output
    logic [CNT_W-1:0]       pack_left_reg;
    logic [CNT_W-1:0]       pack_left_next;
    logic [BUF_W-1:0]       pack_buf_reg;
    logic [BUF_W-1:0]       pack_buf_next;

    logic [CODE_W-1:0]      code_bits;
    logic [LEN_W-1:0]       code_len;
    logic                   clear_partial;
    logic [BUF_W-1:0]       merged;
    logic [TOT_W-1:0]       total_len;
    logic [2:0]             rem_len;
    logic [PART_W-1:0]      rem_mask;
    logic                   pack_free;
    logic                   advance;

    egbp_code #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_code (
        .command       (cmd_reg),
        .value         (value_reg),
        .bit_count     (count_reg),
        .partial_count (partial_count_reg),
        .code_bits     (code_bits),
        .code_len      (code_len),
        .clear_partial (clear_partial)
    );

    // Buffer takes a command when empty or when its last byte leaves now
    assign pack_free = (pack_left_reg == '0) ||
                       ((pack_left_reg == CNT_W'(1)) && out_ready);
    assign advance   = hold_valid_reg && pack_free;
    assign in_ready  = !hold_valid_reg || pack_free;

    // Merge the pending bits ahead of the new code, right-aligned
    assign merged    = (BUF_W'(partial_bits_reg) << code_len) | BUF_W'(code_bits);
    assign total_len = TOT_W'(partial_count_reg) + TOT_W'(code_len);
    assign rem_len   = total_len[2:0];
    assign rem_mask  = ~(PART_W'({PART_W{1'b1}}) << rem_len);

    always_comb
    begin
        if (clear_partial)
        begin
            partial_bits_next  = '0;
            partial_count_next = '0;
        end
        else
        begin
            partial_bits_next  = merged[PART_W-1:0] & rem_mask;
            partial_count_next = rem_len;
        end
    end

    // Load the buffer left-aligned, or shift out the byte just taken
    always_comb
    begin
        pack_left_next = pack_left_reg;
        pack_buf_next  = pack_buf_reg;
        if (advance)
        begin
            pack_left_next = CNT_W'(total_len >> 3);
            pack_buf_next  = merged << (TOT_W'(BUF_W) - total_len);
            if (clear_partial)
            begin
                pack_left_next = '0;
            end
        end
        else if (out_valid && out_ready)
        begin
            pack_left_next = pack_left_reg - CNT_W'(1);
            pack_buf_next  = pack_buf_reg << BYTE_BITS;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg    <= 1'b0;
            partial_bits_reg  <= '0;
            partial_count_reg <= '0;
            pack_left_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                hold_valid_reg <= in_valid;
            end
            if (advance)
            begin
                partial_bits_reg  <= partial_bits_next;
                partial_count_reg <= partial_count_next;
            end
            pack_left_reg <= pack_left_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= command;
            value_reg <= value[VALUE_WIDTH-1:0];
            count_reg <= bit_count;
        end
        pack_buf_reg <= pack_buf_next;
    end

    assign out_valid = (pack_left_reg != '0);
    assign out_byte  = pack_buf_reg[BUF_W-1 -: BYTE_BITS];
    assign last_byte = (pack_left_reg == CNT_W'(1));

`ifndef ASSERT_OFF
    // Buffer never claims more bytes than it holds
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pack_left_reg <= CNT_W'(NBYTES))
        else $error("byte buffer count out of range");

    // Pending bits above the pending count stay zero
    a_part_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (partial_bits_reg >> partial_count_reg) == '0)
        else $error("stale pending bits");

    // Clear empties the pending byte
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (cmd_reg == CMD_CLEAR) |=>
            (partial_count_reg == '0) && (partial_bits_reg == '0) && !out_valid)
        else $error("clear left pending bits");

    // Taking the last byte with nothing new empties the buffer
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_byte && !advance |=> !out_valid)
        else $error("buffer did not drain");
`endif

endmodule
